// ===== rtl/hve_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value equalizer package
// Shared constants, codes, state encoding and control bundles.
// ----------------------------------------------------------------------------
package hve_pkg;

  localparam int unsigned BIN_COUNT = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned BIN_W     = 21;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned DIV_W     = 22;
  localparam int unsigned HUE_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BIN_W-1:0]     BIN_MAX    = {BIN_W{1'b1}};
  localparam logic [DIM_W-1:0]     DIM_RESET  = 11'd128;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_COUNT = 2'd1,
    REQ_MAP   = 2'd2
  } req_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_CNT_RD, S_CNT_WR, S_CUM_RD, S_CUM_WR, S_MAP_RD,
    S_S_GO, S_S_WT, S_H_GO, S_H_WT, S_V_GO, S_V_WT,
    S_MUL_FS, S_MUL_GS, S_MUL_P, S_MUL_Q, S_MUL_T, S_OUT
  } state_e;

  typedef enum logic {ADDR_K, ADDR_MAX} addr_sel_e;
  typedef enum logic [1:0] {WD_ZERO, WD_INC, WD_SUM} wd_sel_e;
  typedef enum logic [1:0] {DIV_S, DIV_H, DIV_V} div_sel_e;
  typedef enum logic [2:0] {MUL_FS, MUL_GS, MUL_P, MUL_Q, MUL_T} mul_sel_e;

  typedef struct packed {
    logic      ram_we;
    logic      ram_re;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      k_inc;
    logic      sum_clr;
    logic      sum_ld;
    logic      latch_pix;
    logic      cdf_ld;
    logic      div_start;
    logic      div_ld;
    div_sel_e  div_sel;
    logic      mul_ld;
    mul_sel_e  mul_sel;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic k_last;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/hve_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value equalizer channels
// Request and pixel result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hve_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source(output valid, req_type, red_in, green_in, blue_in, input ready);
  modport sink(input valid, req_type, red_in, green_in, blue_in, output ready);
endinterface

interface hve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source(output valid, red_out, green_out, blue_out, input ready);
  modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/hve_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hve_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/hve_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider for floor(num * 2^F / den), one quotient bit per cycle;
// a numerator not below the denominator gives exactly one.
// ----------------------------------------------------------------------------
module hve_div
  import hve_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  num_i,
  input  logic [DIV_W-1:0]  den_i,
  output logic [FracBits:0] quo_o,
  output logic              done_o
);

  localparam int unsigned CntW = $clog2(FracBits + 1);
  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  logic              busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DIV_W:0]    rem_q, rem_d, rem2;
  logic [DIV_W-1:0]  den_q, den_d;
  logic [FracBits:0] quo_q, quo_d;
  logic              fits;

  assign rem2 = {rem_q[DIV_W-1:0], 1'b0};
  assign fits = rem2 >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_i;
      if (num_i >= den_i) begin
        quo_d  = One;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = {1'b0, num_i};
        quo_d  = '0;
        cnt_d  = CntW'(FracBits);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = fits ? rem2 - {1'b0, den_q} : rem2;
      quo_d = {quo_q[FracBits-1:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/hve_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value equalizer datapath
// Histogram RAM, configuration, shared divider and multiplier, and the
// output register.
// ----------------------------------------------------------------------------
module hve_datapath
  import hve_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic [CH_W-1:0]      red_i,
  input  logic [CH_W-1:0]      green_i,
  input  logic [CH_W-1:0]      blue_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [CH_W-1:0]      red_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      blue_o
);

  localparam int unsigned QW = FracBits + 1;
  localparam logic [FracBits:0] One = {1'b1, {FracBits{1'b0}}};

  function automatic logic [CH_W-1:0] to_byte(input logic [FracBits:0] x);
    logic [FracBits+8:0] y;
    y = {x, 8'b0} - {8'b0, x};
    return y[FracBits+7:FracBits];
  endfunction

  logic [DIM_W-1:0]  width_q, height_q;
  logic [DIV_W-1:0]  total_q;
  logic [CH_W-1:0]   red_q, green_q, blue_q;
  logic [CH_W-1:0]   mx, mn, d;
  logic [ADDR_W-1:0] k_q, addr;
  logic [BIN_W-1:0]  sum_q, sum_next, cdf_q, rdata, wdata;
  logic [BIN_W:0]    sum_wide;
  logic [HUE_W-1:0]  d_w, d6_w, n_w;
  logic [DIV_W-1:0]  div_num, div_den;
  logic [FracBits:0] quo;
  logic              div_done;
  logic [FracBits:0] s_q, v_q, fs_q, gs_q, p_q, q_q, t_q;
  logic [FracBits-1:0] f_q, h_w;
  logic [FracBits+2:0] h6;
  logic [2:0]        sec_q;
  logic [FracBits:0] ma, mb, mres, ro, go, bo;
  logic [2*QW-1:0]   prod;
  logic              out_valid_q;
  logic [CH_W-1:0]   red_out_q, green_out_q, blue_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= DIV_W'(width_q) * DIV_W'(height_q);
  end

  always_comb begin
    mx = red_q;
    mn = red_q;
    if (green_q > mx) mx = green_q;
    if (blue_q > mx) mx = blue_q;
    if (green_q < mn) mn = green_q;
    if (blue_q < mn) mn = blue_q;
    d = mx - mn;
  end

  assign d_w  = HUE_W'(d);
  assign d6_w = (d_w << 2) + (d_w << 1);

  always_comb begin
    if (mx == red_q) begin
      if (green_q >= blue_q) begin
        n_w = HUE_W'(green_q) - HUE_W'(blue_q);
      end else begin
        n_w = d6_w - (HUE_W'(blue_q) - HUE_W'(green_q));
      end
    end else if (mx == green_q) begin
      n_w = (d_w << 1) + HUE_W'(blue_q) - HUE_W'(red_q);
    end else begin
      n_w = (d_w << 2) + HUE_W'(red_q) - HUE_W'(green_q);
    end
  end

  assign addr     = (cmd_i.addr_sel == ADDR_MAX) ? mx : k_q;
  assign sum_wide = {1'b0, sum_q} + {1'b0, rdata};
  assign sum_next = sum_wide[BIN_W] ? BIN_MAX : sum_wide[BIN_W-1:0];

  always_comb begin
    case (cmd_i.wd_sel)
      WD_INC:  wdata = (rdata == BIN_MAX) ? BIN_MAX : rdata + BIN_W'(1);
      WD_SUM:  wdata = sum_next;
      default: wdata = '0;
    endcase
  end

  hve_ram #(
    .Width(BIN_W),
    .Depth(BIN_COUNT)
  ) u_bins (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(addr),
    .wdata_i(wdata),
    .re_i   (cmd_i.ram_re),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_ld) begin
      sum_q <= sum_next;
    end
    if (cmd_i.latch_pix) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (cmd_i.cdf_ld) begin
      cdf_q <= rdata;
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_S: begin
        div_num = DIV_W'(d);
        div_den = DIV_W'(mx);
      end
      DIV_H: begin
        div_num = DIV_W'(n_w);
        div_den = DIV_W'(d6_w);
      end
      default: begin
        div_num = DIV_W'(cdf_q);
        div_den = total_q;
      end
    endcase
  end

  hve_div #(
    .FracBits(FracBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .done_o (div_done)
  );

  assign h_w = (d == '0) ? '0 : quo[FracBits-1:0];
  assign h6  = ({3'b0, h_w} << 2) + ({3'b0, h_w} << 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_ld && div_done) begin
      case (cmd_i.div_sel)
        DIV_S: s_q <= (mx == '0) ? '0 : quo;
        DIV_H: begin
          sec_q <= h6[FracBits+2:FracBits];
          f_q   <= h6[FracBits-1:0];
        end
        default: v_q <= quo;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_FS: begin
        ma = {1'b0, f_q};
        mb = s_q;
      end
      MUL_GS: begin
        ma = One - {1'b0, f_q};
        mb = s_q;
      end
      MUL_P: begin
        ma = v_q;
        mb = One - s_q;
      end
      MUL_Q: begin
        ma = v_q;
        mb = One - fs_q;
      end
      default: begin
        ma = v_q;
        mb = One - gs_q;
      end
    endcase
  end

  assign prod = ma * mb;
  assign mres = prod[2*FracBits:FracBits];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_ld) begin
      case (cmd_i.mul_sel)
        MUL_FS:  fs_q <= mres;
        MUL_GS:  gs_q <= mres;
        MUL_P:   p_q  <= mres;
        MUL_Q:   q_q  <= mres;
        default: t_q  <= mres;
      endcase
    end
  end

  always_comb begin
    case (sec_q)
      3'd0: begin ro = v_q; go = t_q; bo = p_q; end
      3'd1: begin ro = q_q; go = v_q; bo = p_q; end
      3'd2: begin ro = p_q; go = v_q; bo = t_q; end
      3'd3: begin ro = p_q; go = q_q; bo = v_q; end
      3'd4: begin ro = t_q; go = p_q; bo = v_q; end
      default: begin ro = v_q; go = p_q; bo = q_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      red_out_q   <= to_byte(ro);
      green_out_q <= to_byte(go);
      blue_out_q  <= to_byte(bo);
    end
  end

  assign status_o.k_last   = (k_q == {ADDR_W{1'b1}});
  assign status_o.div_done = div_done;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign red_o       = red_out_q;
  assign green_o     = green_out_q;
  assign blue_o      = blue_out_q;

endmodule

// ===== rtl/hve_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value equalizer controller
// Sequences clearing, counting, cumulation and the per-pixel mapping steps.
// ----------------------------------------------------------------------------
module hve_ctrl
  import hve_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   cum_ready_q, cum_ready_d;
  logic   accept;
  req_e   req;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign req        = req_e'(req_type_i);

  always_comb begin
    state_d     = state_q;
    cum_ready_d = cum_ready_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_CLEAR: begin
              state_d     = S_CLR;
              cum_ready_d = 1'b0;
            end
            REQ_COUNT: state_d = cum_ready_q ? S_IDLE : S_CNT_RD;
            REQ_MAP:   state_d = cum_ready_q ? S_MAP_RD : S_CUM_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_CLR:    if (status_i.k_last) state_d = S_IDLE;
      S_CNT_RD: state_d = S_CNT_WR;
      S_CNT_WR: state_d = S_IDLE;
      S_CUM_RD: state_d = S_CUM_WR;
      S_CUM_WR: begin
        if (status_i.k_last) begin
          state_d     = S_MAP_RD;
          cum_ready_d = 1'b1;
        end else begin
          state_d = S_CUM_RD;
        end
      end
      S_MAP_RD: state_d = S_S_GO;
      S_S_GO:   state_d = S_S_WT;
      S_S_WT:   if (status_i.div_done) state_d = S_H_GO;
      S_H_GO:   state_d = S_H_WT;
      S_H_WT:   if (status_i.div_done) state_d = S_V_GO;
      S_V_GO:   state_d = S_V_WT;
      S_V_WT:   if (status_i.div_done) state_d = S_MUL_FS;
      S_MUL_FS: state_d = S_MUL_GS;
      S_MUL_GS: state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_Q;
      S_MUL_Q:  state_d = S_MUL_T;
      S_MUL_T:  state_d = S_OUT;
      S_OUT:    if (!status_i.out_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = ADDR_K;
    cmd_o.wd_sel   = WD_ZERO;
    cmd_o.div_sel  = DIV_S;
    cmd_o.mul_sel  = MUL_FS;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch_pix = accept;
        cmd_o.sum_clr   = accept && (req == REQ_MAP) && !cum_ready_q;
      end
      S_CLR: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.k_inc  = 1'b1;
      end
      S_CNT_RD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.addr_sel = ADDR_MAX;
      end
      S_CNT_WR: begin
        cmd_o.ram_we   = 1'b1;
        cmd_o.addr_sel = ADDR_MAX;
        cmd_o.wd_sel   = WD_INC;
      end
      S_CUM_RD: cmd_o.ram_re = 1'b1;
      S_CUM_WR: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.wd_sel = WD_SUM;
        cmd_o.sum_ld = 1'b1;
        cmd_o.k_inc  = 1'b1;
      end
      S_MAP_RD: begin
        cmd_o.ram_re   = 1'b1;
        cmd_o.addr_sel = ADDR_MAX;
      end
      S_S_GO: begin
        cmd_o.cdf_ld    = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      S_S_WT: cmd_o.div_ld = 1'b1;
      S_H_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_H;
      end
      S_H_WT: begin
        cmd_o.div_ld  = 1'b1;
        cmd_o.div_sel = DIV_H;
      end
      S_V_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_V;
      end
      S_V_WT: begin
        cmd_o.div_ld  = 1'b1;
        cmd_o.div_sel = DIV_V;
      end
      S_MUL_FS: cmd_o.mul_ld = 1'b1;
      S_MUL_GS: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = MUL_GS;
      end
      S_MUL_P: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = MUL_P;
      end
      S_MUL_Q: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = MUL_Q;
      end
      S_MUL_T: begin
        cmd_o.mul_ld  = 1'b1;
        cmd_o.mul_sel = MUL_T;
      end
      S_OUT:   cmd_o.out_ld = !status_i.out_busy;
      default: cmd_o.latch_pix = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cum_ready_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cum_ready_q <= cum_ready_d;
    end
  end

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ram_we |-> !cmd_o.ram_re)
    else $error("Histogram RAM read and written in the same cycle.");

  a_no_count_after_cum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CNT_WR |-> !cum_ready_q)
    else $error("Bin count written after cumulation.");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> !status_i.out_busy)
    else $error("Result overwrites an item not yet taken.");

  a_cum_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CUM_WR && status_i.k_last) |=> (cum_ready_q && state_q == S_MAP_RD))
    else $error("Cumulation pass ended without marking the bins.");

endmodule

// ===== rtl/hsv_value_histogram_equalizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value histogram equalizer
// Builds a 256-bin histogram of max(r,g,b), cumulates it, and maps pixels
// through HSV with the equalized value.
// ----------------------------------------------------------------------------
// Clear: one histogram RAM write per bin. Count: a read-modify-write on the
// histogram RAM. Map: three passes of the bit-serial divider and five steps
// of the shared multiplier; the first map after counting adds a cumulative
// sweep over all bins. After reset a clearing pass runs before the first
// item is accepted; configuration writes are taken at once.
module hsv_value_histogram_equalizer_unit
  import hve_pkg::*;
#(
  parameter int unsigned FractionBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  hve_in_if.sink               in_i,
  hve_out_if.source            out_o
);

  cmd_t    cmd;
  status_t status;

  hve_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .req_type_i(in_i.req_type),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  hve_datapath #(
    .FracBits(FractionBits)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .red_i      (in_i.red_in),
    .green_i    (in_i.green_in),
    .blue_i     (in_i.blue_in),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .red_o      (out_o.red_out),
    .green_o    (out_o.green_out),
    .blue_o     (out_o.blue_out)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV value equalizer testbench
// Drives clear, count and map requests with random idling on both channels,
// predicts each equalized pixel from a local histogram and checks it field by
// field against the block's output.
// ----------------------------------------------------------------------------
module testbench;
  import hve_pkg::*;

  localparam int unsigned FB = 16;
  localparam longint unsigned ONE = 64'd1 << FB;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WIDTH;
  logic [DIM_W-1:0] cfg_data_i = '0;

  hve_in_if in_ch();
  hve_out_if out_ch();

  hsv_value_histogram_equalizer_unit #(.FractionBits(FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  longint unsigned img_w = 128, img_h = 128;
  longint unsigned hist [BIN_COUNT];
  bit cdf_valid;
  pixel_t pending_pixels[$];
  int errors = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_CLEAR;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
  end

  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic longint unsigned fx_byte(input longint unsigned x);
    longint unsigned c;
    c = (x * 255) >> FB;
    return c > 255 ? 255 : c;
  endfunction

  function automatic pixel_t equalize(input pixel_t px);
    longint unsigned r, g, b, mx, mn, d, h, s, v, n, tot, h6, sec, f, p, q, t;
    pixel_t res;
    r = px.r; g = px.g; b = px.b;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (!cdf_valid) begin
      longint unsigned acc = 0;
      for (int k = 0; k < BIN_COUNT; k++) begin
        acc += hist[k];
        if (acc > BIN_MAX) acc = BIN_MAX;
        hist[k] = acc;
      end
      cdf_valid = 1'b1;
    end
    d = mx - mn;
    h = 0; s = 0;
    if (mx != 0) s = (d << FB) / mx;
    if (d != 0) begin
      if (mx == r) n = (g >= b) ? (g - b) : (6 * d - (b - g));
      else if (mx == g) n = 2 * d + b - r;
      else n = 4 * d + r - g;
      h = (n << FB) / (6 * d);
    end
    tot = img_w * img_h;
    if (tot == 0) v = ONE;
    else begin
      v = (hist[mx] << FB) / tot;
      if (v > ONE) v = ONE;
    end
    h6 = h * 6;
    sec = h6 >> FB;
    f = h6 - (sec << FB);
    p = (v * (ONE - s)) >> FB;
    q = (v * (ONE - ((f * s) >> FB))) >> FB;
    t = (v * (ONE - (((ONE - f) * s) >> FB))) >> FB;
    case (sec)
      0: begin r = v; g = t; b = p; end
      1: begin r = q; g = v; b = p; end
      2: begin r = p; g = v; b = t; end
      3: begin r = p; g = q; b = v; end
      4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
    res.r = 8'(fx_byte(r));
    res.g = 8'(fx_byte(g));
    res.b = 8'(fx_byte(b));
    return res;
  endfunction

  function automatic void predict(input logic [1:0] req, input pixel_t px);
    int mx;
    mx = px.r;
    if (px.g > mx) mx = px.g;
    if (px.b > mx) mx = px.b;
    if (req == REQ_CLEAR) begin
      foreach (hist[k]) hist[k] = 0;
      cdf_valid = 1'b0;
    end else if (req == REQ_COUNT) begin
      if (!cdf_valid && hist[mx] < BIN_MAX) hist[mx]++;
    end else if (req == REQ_MAP) begin
      pending_pixels.push_back(equalize(px));
    end
  endfunction

  task automatic send_item(input logic [1:0] req, input pixel_t px);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.red_in <= px.r;
    in_ch.green_in <= px.g;
    in_ch.blue_in <= px.b;
    do @(posedge clk_i); while (!in_ch.ready);
    predict(req, px);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px = 24'($urandom);
    case ($urandom_range(0, 5))
      0: px.g = px.r;
      1: px.b = px.r;
      2: begin px.g = px.r; px.b = px.r; end
      default: ;
    endcase
    return px;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= DIM_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WIDTH) img_w = val;
    else img_h = val;
    @(posedge clk_i);
  endtask

  task automatic run_frame(input int counts, input int maps);
    send_item(REQ_CLEAR, rand_pixel());
    repeat (counts) send_item(REQ_COUNT, rand_pixel());
    repeat (maps) begin
      if ($urandom_range(0, 30) == 0) send_item(REQ_COUNT, rand_pixel());
      send_item(REQ_MAP, rand_pixel());
    end
  endtask

  task automatic test_directed();
    send_item(REQ_MAP, 24'h102030);
    send_item(2'd3, 24'hFFFFFF);
    send_item(REQ_CLEAR, 24'h0);
    send_item(REQ_COUNT, 24'h000000);
    send_item(REQ_COUNT, 24'hFFFFFF);
    send_item(REQ_COUNT, 24'hFF0000);
    send_item(REQ_COUNT, 24'h00FF00);
    send_item(REQ_COUNT, 24'h0000FF);
    send_item(REQ_COUNT, 24'h808080);
    send_item(REQ_MAP, 24'h000000);
    send_item(REQ_COUNT, 24'h808080);
    send_item(REQ_MAP, 24'hFFFFFF);
    send_item(REQ_MAP, 24'hFF0010);
    send_item(REQ_MAP, 24'hFF1000);
    send_item(REQ_MAP, 24'h10FF00);
    send_item(REQ_MAP, 24'h0010FF);
    send_item(REQ_MAP, 24'hFFFF00);
    send_item(REQ_MAP, 24'h00FFFF);
    send_item(REQ_MAP, 24'h808080);
    send_item(2'd3, 24'h123456);
    drain();
  endtask

  task automatic test_dimensions();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 1);
    run_frame(12, 10);
    drain();
    write_reg(CFG_WIDTH, 0);
    run_frame(4, 6);
    drain();
    write_reg(CFG_WIDTH, 1024);
    write_reg(CFG_HEIGHT, 1024);
    run_frame(20, 10);
    drain();
    write_reg(CFG_WIDTH, 2047);
    write_reg(CFG_HEIGHT, 2047);
    run_frame(5, 5);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_HEIGHT, 4);
    send_item(REQ_CLEAR, 24'h0);
    repeat (16) send_item(REQ_COUNT, rand_pixel());
    hold_cycles = 3000;
    repeat (8) send_item(REQ_MAP, rand_pixel());
    drain();
  endtask

  task automatic test_random();
    int w, h;
    for (int fr = 0; fr < 50; fr++) begin
      w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 12);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 12);
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      run_frame($urandom_range(0, w * h > 40 ? 40 : w * h), $urandom_range(5, 15));
      drain();
    end
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(CFG_WIDTH, 5);
    write_reg(CFG_HEIGHT, 5);
    run_frame(25, 20);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_idle) begin
      out_ch.ready <= $urandom_range(0, 3) != 0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel", 0, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.red_out !== want.r) report("red", out_ch.red_out, want.r);
        if (out_ch.green_out !== want.g) report("green", out_ch.green_out, want.g);
        if (out_ch.blue_out !== want.b) report("blue", out_ch.blue_out, want.b);
      end
    end
  end

  initial begin
    foreach (hist[k]) hist[k] = 0;
    cdf_valid = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_dimensions();
    test_backpressure();
    test_random();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
